// ----- rtl/sample_ring_buffer_top_assert.svh -----
// assertion macros used by srb_datapath
`ifndef SAMPLE_RING_BUFFER_TOP_ASSERT_SVH
`define SAMPLE_RING_BUFFER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SRB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SRB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SRB_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define SRB_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/srb_pkg.sv -----
package srb_pkg;

    localparam int CW = 9;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_RECENT = 2'd1;
    localparam logic [1:0] FUNC_OLDEST = 2'd2;
    localparam logic [1:0] FUNC_FILL   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NAN   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FILL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic fill_step;
        logic capture_read;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_fill;
        logic fill_empty;
        logic fill_last;
    } sts_t;

endpackage

// ----- rtl/sample_ring_buffer_top.sv -----
// ring buffer of 64-bit binary64 samples with a runtime capacity
// input channel: in_valid / in_stall with func, sample_bits, age_index
// output channel: out_valid / out_stall with read_bits, status, stored_count
// config channel: cfg_valid / cfg_ready with capacity, taken only while idle with no request
// writing capacity empties the buffer
// one request is handled at a time; in_stall stays high until its result is taken
// add: result in the cycle after acceptance, no nan check on fill
// reads: the memory read is registered at acceptance, captured in S_READ, then shown in S_OUT
// fill: S_FILL writes every stored slot, one memory write a cycle, then S_OUT; an empty buffer skips S_FILL
// a new request is accepted only once the result of the previous one has been taken
// a stalled result holds on the output until out_stall drops
// reset: capacity 256, buffer empty, no result pending, no clearing pass
module sample_ring_buffer_top
#(
    parameter int DEPTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             func,
    input  logic [63:0]            sample_bits,
    input  logic [7:0]             age_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [63:0]            read_bits,
    output logic [1:0]             status,
    output logic [srb_pkg::CW-1:0] stored_count,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [srb_pkg::CW-1:0] capacity
);

    srb_pkg::cmd_t cmd;
    srb_pkg::sts_t sts;

    srb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    srb_datapath #(.DEPTH(DEPTH)) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .func         (func),
        .sample_bits  (sample_bits),
        .age_index    (age_index),
        .cfg_we       (cfg_valid && cfg_ready),
        .capacity     (capacity),
        .read_bits    (read_bits),
        .status       (status),
        .stored_count (stored_count)
    );

endmodule

// ----- rtl/srb_ctrl.sv -----
module srb_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          cfg_ready,
    input  srb_pkg::sts_t sts,
    output srb_pkg::cmd_t cmd
);

    srb_pkg::state_t state_reg;
    srb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd.accept       = 1'b0;
        cmd.fill_step    = 1'b0;
        cmd.capture_read = 1'b0;
        in_stall         = 1'b1;
        out_valid        = 1'b0;
        cfg_ready        = 1'b0;
        unique case (state_reg)
            srb_pkg::S_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = !in_valid;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    priority if (sts.is_read)
                    begin
                        state_next = srb_pkg::S_READ;
                    end
                    else if (sts.is_fill && !sts.fill_empty)
                    begin
                        state_next = srb_pkg::S_FILL;
                    end
                    else
                    begin
                        state_next = srb_pkg::S_OUT;
                    end
                end
            end
            srb_pkg::S_READ:
            begin
                cmd.capture_read = 1'b1;
                state_next       = srb_pkg::S_OUT;
            end
            srb_pkg::S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = srb_pkg::S_OUT;
                end
            end
            srb_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = srb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/srb_datapath.sv -----
`include "sample_ring_buffer_top_assert.svh"

module srb_datapath
#(
    parameter int DEPTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  srb_pkg::cmd_t          cmd,
    output srb_pkg::sts_t          sts,
    input  logic [1:0]             func,
    input  logic [63:0]            sample_bits,
    input  logic [7:0]             age_index,
    input  logic                   cfg_we,
    input  logic [srb_pkg::CW-1:0] capacity,
    output logic [63:0]            read_bits,
    output logic [1:0]             status,
    output logic [srb_pkg::CW-1:0] stored_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = srb_pkg::CW;

    logic [63:0]   mem [DEPTH];

    logic [CW-1:0] cap_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] wp_reg;
    logic [CW-1:0] wp_next;
    logic [CW-1:0] fill_idx_reg;
    logic [63:0]   fill_val_reg;
    logic [63:0]   rd_data_reg;
    logic [63:0]   read_bits_reg;
    logic [1:0]    status_reg;
    logic [CW-1:0] out_count_reg;

    logic [CW-1:0] eff_cap;
    logic          is_nan;
    logic          add_ok;
    logic [CW-1:0] k;
    logic          range_err;
    logic [CW-1:0] last;
    logic [CW-1:0] first;
    logic [CW:0]   sum;
    logic [CW-1:0] slot;
    logic [1:0]    st;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (32'(cap_reg) > DEPTH)
        begin
            eff_cap = CW'(DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign is_nan = (sample_bits[62:52] == 11'h7FF) && (sample_bits[51:0] != 52'd0);
    assign add_ok = (func == srb_pkg::FUNC_ADD) && !is_nan;
    assign k      = CW'(age_index);

    assign count_next = (count_reg >= eff_cap) ? eff_cap : count_reg + CW'(1);
    assign wp_next    = ((wp_reg + CW'(1)) == eff_cap) ? '0 : wp_reg + CW'(1);

    // slot of the k-th newest or k-th oldest sample
    always_comb
    begin
        last  = (wp_reg != '0) ? wp_reg - CW'(1) : count_reg - CW'(1);
        first = (wp_reg == count_reg) ? '0 : wp_reg;
        sum   = {1'b0, first} + {1'b0, k};
        if (func == srb_pkg::FUNC_RECENT)
        begin
            slot = (last >= k) ? last - k : count_reg + last - k;
        end
        else
        begin
            slot = (sum >= {1'b0, count_reg}) ? CW'(sum - {1'b0, count_reg}) : CW'(sum);
        end
        range_err = (count_reg == '0) || (k >= count_reg) || !(32'(slot) < DEPTH);
    end

    always_comb
    begin
        unique case (func)
            srb_pkg::FUNC_ADD:    st = is_nan ? srb_pkg::ST_NAN : srb_pkg::ST_OK;
            srb_pkg::FUNC_RECENT: st = range_err ? srb_pkg::ST_RANGE : srb_pkg::ST_OK;
            srb_pkg::FUNC_OLDEST: st = range_err ? srb_pkg::ST_RANGE : srb_pkg::ST_OK;
            default:              st = srb_pkg::ST_OK;
        endcase
    end

    assign sts.is_read    = (func == srb_pkg::FUNC_RECENT) || (func == srb_pkg::FUNC_OLDEST);
    assign sts.is_fill    = (func == srb_pkg::FUNC_FILL);
    assign sts.fill_empty = (count_reg == '0);
    assign sts.fill_last  = ({1'b0, fill_idx_reg} + (CW+1)'(1)) >= {1'b0, count_reg};

    assign mem_we    = (cmd.accept && add_ok) || cmd.fill_step;
    assign mem_waddr = cmd.fill_step ? AW'(fill_idx_reg) : AW'(wp_reg);
    assign mem_wdata = cmd.fill_step ? fill_val_reg : sample_bits;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[AW'(slot)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CW'(256);
            count_reg <= '0;
            wp_reg    <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= capacity;
            count_reg <= '0;
            wp_reg    <= '0;
        end
        else if (cmd.accept && add_ok)
        begin
            count_reg <= count_next;
            wp_reg    <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            fill_idx_reg  <= '0;
            fill_val_reg  <= sample_bits;
            read_bits_reg <= '0;
            status_reg    <= st;
            out_count_reg <= add_ok ? count_next : count_reg;
        end
        else
        begin
            if (cmd.fill_step)
            begin
                fill_idx_reg <= fill_idx_reg + CW'(1);
            end
            if (cmd.capture_read)
            begin
                read_bits_reg <= (status_reg == srb_pkg::ST_OK) ? rd_data_reg : '0;
            end
        end
    end

    assign read_bits    = read_bits_reg;
    assign status       = status_reg;
    assign stored_count = out_count_reg;

    `SRB_ASSERT_IMP(a_count_le_cap, clk, rst_n, 1'b1, count_reg <= eff_cap)
    `SRB_ASSERT_IMP(a_wp_lt_cap, clk, rst_n, 1'b1, wp_reg < eff_cap)
    `SRB_ASSERT_IMP(a_wp_tracks_count, clk, rst_n, count_reg != eff_cap, wp_reg == count_reg)
    `SRB_ASSERT_NXT(a_add_fills, clk, rst_n, cmd.accept && add_ok && !cfg_we, count_reg != '0)

endmodule
